// ===== sv/humidity_sensor_frame_decoder_core_assert.svh =====
// Assertion macros used by the checker file of this block.
`ifndef HUMIDITY_SENSOR_FRAME_DECODER_CORE_ASSERT_SVH
`define HUMIDITY_SENSOR_FRAME_DECODER_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define HSFD_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("hsfd check failed");

// Next-cycle implication, disabled during reset
`define HSFD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("hsfd check failed");

`endif

// ===== sv/hsfd_pkg.sv =====
package hsfd_pkg;

   // Depth of the job queue between front and back
   localparam int unsigned FIFO_DEPTH = 4;

   // Field widths
   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned RAW_W    = 16;
   localparam int unsigned TEMP_W   = 15;
   localparam int unsigned HUM_W    = 14;
   localparam int unsigned STATUS_W = 2;
   localparam int unsigned TDATA_W  = 32;
   localparam int unsigned TPROD_W  = 31;
   localparam int unsigned HPROD_W  = 30;

   // CRC-8, polynomial 0x31, no reflection, no final xor
   localparam logic [BYTE_W-1:0] CRC_INIT = 8'hFF;
   localparam logic [BYTE_W-1:0] CRC_POLY = 8'h31;

   // Conversion constants (hundredths of a unit)
   localparam logic [TEMP_W-1:0] TEMP_SPAN   = 15'd17500;
   localparam logic [TEMP_W-1:0] TEMP_OFFSET = 15'd4500;
   localparam logic signed [TEMP_W-1:0] TEMP_MIN = -15'sd4500;
   localparam logic signed [TEMP_W-1:0] TEMP_MAX = 15'sd13000;
   localparam logic [HUM_W-1:0]  HUM_SPAN    = 14'd12500;
   localparam logic [HUM_W-1:0]  HUM_OFFSET  = 14'd600;
   localparam logic [HUM_W-1:0]  HUM_MAX     = 14'd10000;
   localparam logic [HUM_W-1:0]  HUM_CLIP_HI = 14'd10600;

   // Result status codes
   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK       = 2'd0,
      STATUS_TEMP_CRC = 2'd1,
      STATUS_HUM_CRC  = 2'd2,
      STATUS_SHORT    = 2'd3
   } status_type;

   // Position of the next byte in the response frame
   typedef enum logic [2:0] {
      POS_TEMP_HI  = 3'd0,
      POS_TEMP_LO  = 3'd1,
      POS_TEMP_CRC = 3'd2,
      POS_HUM_HI   = 3'd3,
      POS_HUM_LO   = 3'd4,
      POS_HUM_CRC  = 3'd5
   } byte_pos_type;

   // One classified frame handed from front to back
   typedef struct packed {
      status_type             status;
      logic [RAW_W-1:0]       temp_raw;
      logic [RAW_W-1:0]       hum_raw;
   } job_type;

   // One byte step of the CRC, unrolled over eight bits
   function automatic logic [BYTE_W-1:0] crc8_byte(input logic [BYTE_W-1:0] crc,
                                                   input logic [BYTE_W-1:0] data);
      logic [BYTE_W-1:0] c;
      c = crc ^ data;
      for (int k = 0; k < BYTE_W; k++) begin
         if (c[BYTE_W-1]) begin
            c = {c[BYTE_W-2:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[BYTE_W-2:0], 1'b0};
         end
      end
      return c;
   endfunction

   // floor(x / 65535) for x below 2^31: (x + (x >> 16) + 1) >> 16
   function automatic logic [RAW_W-1:0] div65535(input logic [31:0] x);
      logic [31:0] sum;
      sum = x + {16'd0, x[31:16]} + 32'd1;
      return sum[31:16];
   endfunction

endpackage

// ===== sv/hsfd_fifo.sv =====
module hsfd_fifo #(
   parameter int unsigned DEPTH = hsfd_pkg::FIFO_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   input  hsfd_pkg::job_type  push_job,
   output logic               full,
   input  logic               pop_ready,
   output logic               pop_valid,
   output hsfd_pkg::job_type  pop_job
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   hsfd_pkg::job_type  mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff,  count_in;
   logic               push_fire, pop_fire;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_job   = mem_ff[rd_ptr_ff];
   assign push_fire = push_valid && !full;
   assign pop_fire  = pop_ready && pop_valid;

   // Pointer and occupancy update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_fire) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop_fire) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      case ({push_fire, pop_fire})
         2'b10:   count_in = count_ff + CNT_W'(1);
         2'b01:   count_in = count_ff - CNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (push_fire) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

// ===== sv/hsfd_front.sv =====
module hsfd_front (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [hsfd_pkg::BYTE_W-1:0]    req_tdata,
   input  logic                           req_tuser,
   input  logic                           fifo_full,
   output logic                           push_valid,
   output hsfd_pkg::job_type              push_job
);

   hsfd_pkg::byte_pos_type              pos_ff, pos_in, pos_eff;
   logic [hsfd_pkg::BYTE_W-1:0]         crc_ff, crc_in;
   logic [hsfd_pkg::RAW_W-1:0]          temp_raw_ff, temp_raw_in;
   logic [hsfd_pkg::RAW_W-1:0]          hum_raw_ff, hum_raw_in;
   logic                                temp_ok_ff, temp_ok_in;
   logic                                accept;

   // Each byte yields at most one job, so a free queue slot is enough
   assign req_tready = !fifo_full;
   assign accept     = req_tvalid && req_tready;

   // Frame tracking, CRC and job classification
   always_comb begin
      pos_in      = pos_ff;
      crc_in      = crc_ff;
      temp_raw_in = temp_raw_ff;
      hum_raw_in  = hum_raw_ff;
      temp_ok_in  = temp_ok_ff;
      push_valid  = 1'b0;
      push_job    = '{status: hsfd_pkg::STATUS_SHORT, temp_raw: temp_raw_ff,
                      hum_raw: hum_raw_ff};

      case (pos_ff)
         hsfd_pkg::POS_TEMP_HI,
         hsfd_pkg::POS_TEMP_LO,
         hsfd_pkg::POS_TEMP_CRC,
         hsfd_pkg::POS_HUM_HI,
         hsfd_pkg::POS_HUM_LO,
         hsfd_pkg::POS_HUM_CRC: pos_eff = pos_ff;
         default:               pos_eff = hsfd_pkg::POS_TEMP_HI;
      endcase

      if (accept) begin
         // early frame start: report the partial frame, restart at byte 0
         if (req_tuser && (pos_eff != hsfd_pkg::POS_TEMP_HI)) begin
            push_valid      = 1'b1;
            push_job.status = hsfd_pkg::STATUS_SHORT;
            pos_eff         = hsfd_pkg::POS_TEMP_HI;
         end

         case (pos_eff)
            hsfd_pkg::POS_TEMP_HI: begin
               crc_in      = hsfd_pkg::crc8_byte(hsfd_pkg::CRC_INIT, req_tdata);
               temp_raw_in = {req_tdata, 8'd0};
               pos_in      = hsfd_pkg::POS_TEMP_LO;
            end
            hsfd_pkg::POS_TEMP_LO: begin
               crc_in      = hsfd_pkg::crc8_byte(crc_ff, req_tdata);
               temp_raw_in = {temp_raw_ff[15:8], req_tdata};
               pos_in      = hsfd_pkg::POS_TEMP_CRC;
            end
            hsfd_pkg::POS_TEMP_CRC: begin
               temp_ok_in = (crc_ff == req_tdata);
               crc_in     = hsfd_pkg::CRC_INIT;
               pos_in     = hsfd_pkg::POS_HUM_HI;
            end
            hsfd_pkg::POS_HUM_HI: begin
               crc_in     = hsfd_pkg::crc8_byte(crc_ff, req_tdata);
               hum_raw_in = {req_tdata, hum_raw_ff[7:0]};
               pos_in     = hsfd_pkg::POS_HUM_LO;
            end
            hsfd_pkg::POS_HUM_LO: begin
               crc_in     = hsfd_pkg::crc8_byte(crc_ff, req_tdata);
               hum_raw_in = {hum_raw_ff[15:8], req_tdata};
               pos_in     = hsfd_pkg::POS_HUM_CRC;
            end
            default: begin
               // humidity CRC byte closes the frame
               push_valid = 1'b1;
               if (!temp_ok_ff) begin
                  push_job.status = hsfd_pkg::STATUS_TEMP_CRC;
               end else if (crc_ff != req_tdata) begin
                  push_job.status = hsfd_pkg::STATUS_HUM_CRC;
               end else begin
                  push_job.status = hsfd_pkg::STATUS_OK;
               end
               crc_in = hsfd_pkg::CRC_INIT;
               pos_in = hsfd_pkg::POS_TEMP_HI;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff     <= hsfd_pkg::POS_TEMP_HI;
         crc_ff     <= hsfd_pkg::CRC_INIT;
         temp_ok_ff <= 1'b0;
      end else begin
         pos_ff     <= pos_in;
         crc_ff     <= crc_in;
         temp_ok_ff <= temp_ok_in;
      end
   end

   // Held data bytes
   always_ff @(posedge clock) begin
      temp_raw_ff <= temp_raw_in;
      hum_raw_ff  <= hum_raw_in;
   end

endmodule

// ===== sv/hsfd_back.sv =====
module hsfd_back (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              pop_valid,
   input  hsfd_pkg::job_type                 pop_job,
   output logic                              pop_ready,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [hsfd_pkg::TDATA_W-1:0]      rsp_tdata,
   output logic [hsfd_pkg::STATUS_W-1:0]     rsp_tuser
);

   localparam int unsigned PAD_W = hsfd_pkg::TDATA_W - hsfd_pkg::TEMP_W - hsfd_pkg::HUM_W;

   // Stage 1: scaling products
   logic                              s1_valid_ff, s1_valid_in;
   hsfd_pkg::status_type              s1_status_ff;
   logic [hsfd_pkg::TPROD_W-1:0]      s1_temp_prod_ff, s1_temp_prod_in;
   logic [hsfd_pkg::HPROD_W-1:0]      s1_hum_prod_ff, s1_hum_prod_in;

   // Stage 2: output register
   logic                              out_valid_ff, out_valid_in;
   hsfd_pkg::status_type              out_status_ff;
   logic [hsfd_pkg::TEMP_W-1:0]       out_temp_ff, out_temp_in;
   logic [hsfd_pkg::HUM_W-1:0]        out_hum_ff, out_hum_in;

   logic                              adv_out, adv_s1;
   logic [hsfd_pkg::RAW_W-1:0]        temp_q, hum_q;

   assign adv_out   = !out_valid_ff || rsp_tready;
   assign adv_s1    = !s1_valid_ff || adv_out;
   assign pop_ready = adv_s1;

   // Multiply by the span; divide comes in the next stage
   assign s1_valid_in     = adv_s1 ? pop_valid : s1_valid_ff;
   assign s1_temp_prod_in = hsfd_pkg::TPROD_W'(pop_job.temp_raw)
                            * hsfd_pkg::TPROD_W'(hsfd_pkg::TEMP_SPAN);
   assign s1_hum_prod_in  = hsfd_pkg::HPROD_W'(pop_job.hum_raw)
                            * hsfd_pkg::HPROD_W'(hsfd_pkg::HUM_SPAN);

   // Divide by 65535, offset, clamp humidity, zero fields on a bad frame
   always_comb begin
      temp_q       = hsfd_pkg::div65535(32'(s1_temp_prod_ff));
      hum_q        = hsfd_pkg::div65535(32'(s1_hum_prod_ff));
      out_valid_in = adv_out ? s1_valid_ff : out_valid_ff;
      out_temp_in  = hsfd_pkg::TEMP_W'(temp_q) - hsfd_pkg::TEMP_OFFSET;
      if (hum_q < hsfd_pkg::RAW_W'(hsfd_pkg::HUM_OFFSET)) begin
         out_hum_in = '0;
      end else if (hum_q > hsfd_pkg::RAW_W'(hsfd_pkg::HUM_CLIP_HI)) begin
         out_hum_in = hsfd_pkg::HUM_MAX;
      end else begin
         out_hum_in = hsfd_pkg::HUM_W'(hum_q - hsfd_pkg::RAW_W'(hsfd_pkg::HUM_OFFSET));
      end
      if (s1_status_ff != hsfd_pkg::STATUS_OK) begin
         out_temp_in = '0;
         out_hum_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (adv_s1 && pop_valid) begin
         s1_status_ff    <= pop_job.status;
         s1_temp_prod_ff <= s1_temp_prod_in;
         s1_hum_prod_ff  <= s1_hum_prod_in;
      end
      if (adv_out && s1_valid_ff) begin
         out_status_ff <= s1_status_ff;
         out_temp_ff   <= out_temp_in;
         out_hum_ff    <= out_hum_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{PAD_W{1'b0}}, out_hum_ff, out_temp_ff};
   assign rsp_tuser  = out_status_ff;

endmodule

// ===== sv/humidity_sensor_frame_decoder_core.sv =====
// Temperature and humidity sensor response frame decoder.
// req channel: one response byte per transaction in wire order (temperature
//   high, low, CRC, humidity high, low, CRC); req_tuser marks a frame start.
// rsp channel: one transaction per frame with status in rsp_tuser and the
//   converted readings in rsp_tdata; fields are zero unless status is ok.
// A frame start in the middle of a frame yields a short-frame transaction
//   and the byte opens a new frame.
// Throughput: one byte per cycle while the queue is not full. The front
//   tracks position and CRC and pushes a job into a FIFO_DEPTH-entry queue.
// Path: the result of a frame passes the queue, the multiply stage and the
//   divide/clamp output register before it shows on rsp.
// Stall: while rsp_tready is low the back holds its result and the queue
//   fills; req_tready drops only when the queue is full.
// Reset: synchronous, active high; clears frame position, CRC, queue and
//   pipeline valids, so the next byte is taken as the first of a frame.
module humidity_sensor_frame_decoder_core #(
   parameter int unsigned FIFO_DEPTH = hsfd_pkg::FIFO_DEPTH
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [hsfd_pkg::BYTE_W-1:0]       req_tdata,   // [7:0] rx_byte
   input  logic                              req_tuser,   // [0] frame_start
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [14:0] temperature_centideg, [28:15] humidity_centipct, [31:29] zero
   output logic [hsfd_pkg::TDATA_W-1:0]      rsp_tdata,
   output logic [hsfd_pkg::STATUS_W-1:0]     rsp_tuser    // [1:0] status
);

   logic               push_valid, fifo_full, pop_valid, pop_ready;
   hsfd_pkg::job_type  push_job, pop_job;

   // Byte intake and frame classification
   hsfd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .fifo_full  (fifo_full),
      .push_valid (push_valid),
      .push_job   (push_job)
   );

   // Job queue between front and back
   hsfd_fifo #(
      .DEPTH (FIFO_DEPTH)
   ) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_job   (push_job),
      .full       (fifo_full),
      .pop_ready  (pop_ready),
      .pop_valid  (pop_valid),
      .pop_job    (pop_job)
   );

   // Unit conversion and result register
   hsfd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_valid  (pop_valid),
      .pop_job    (pop_job),
      .pop_ready  (pop_ready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

// ===== sv/hsfd_checker.sv =====
`include "humidity_sensor_frame_decoder_core_assert.svh"

module hsfd_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [hsfd_pkg::TDATA_W-1:0]      rsp_tdata,
   input logic [hsfd_pkg::STATUS_W-1:0]     rsp_tuser
);

   // A stalled result transaction holds
   `HSFD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))

   // Bad or short frames carry zero readings
   `HSFD_ASSERT_IMPLY(a_err_zero, clock, reset, rsp_tvalid && (rsp_tuser != hsfd_pkg::STATUS_OK), rsp_tdata == '0)

   // Humidity is clamped to full scale
   `HSFD_ASSERT_IMPLY(a_hum_range, clock, reset, rsp_tvalid, rsp_tdata[28:15] <= hsfd_pkg::HUM_MAX)

   // Temperature stays within the sensor span
   `HSFD_ASSERT_IMPLY(a_temp_range, clock, reset, rsp_tvalid, ($signed(rsp_tdata[14:0]) >= hsfd_pkg::TEMP_MIN) && ($signed(rsp_tdata[14:0]) <= hsfd_pkg::TEMP_MAX))

endmodule

bind humidity_sensor_frame_decoder_core hsfd_checker u_hsfd_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
